// File: hdl/bdar_pkg.sv
// bdar_pkg: shared types, register codes and reset values for the button debounce block
// depends on nothing; imported by bdar_update and button_debounce_auto_repeat
package bdar_pkg;

  localparam int unsigned NumButtonsDef = 4;
  localparam int unsigned LevelW        = 4;
  localparam int unsigned RunW          = 10;
  localparam int unsigned HoldW         = 16;
  localparam int unsigned PerW          = 10;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned CfgDataW      = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegInitDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSlowPeriod   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFastPeriod   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSlowStart    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFastStart    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegHoldLimit    = 3'd5;

  localparam logic [PerW-1:0]  InitDebounceRst = 10'd50;
  localparam logic [PerW-1:0]  SlowPeriodRst   = 10'd500;
  localparam logic [PerW-1:0]  FastPeriodRst   = 10'd150;
  localparam logic [HoldW-1:0] SlowStartRst    = 16'd50;
  localparam logic [HoldW-1:0] FastStartRst    = 16'd650;
  localparam logic [HoldW-1:0] HoldLimitRst    = 16'd1400;

  localparam logic [RunW-1:0]  RunMax  = '1;
  localparam logic [HoldW-1:0] HoldMax = '1;

  typedef struct packed {
    logic [PerW-1:0]  init_debounce;
    logic [PerW-1:0]  slow_period;
    logic [PerW-1:0]  fast_period;
    logic [HoldW-1:0] slow_start;
    logic [HoldW-1:0] fast_start;
    logic [HoldW-1:0] hold_limit;
  } cfg_t;

  typedef struct packed {
    logic [RunW-1:0]  run;
    logic [HoldW-1:0] hold;
    logic [PerW-1:0]  period;
  } entry_t;

  localparam entry_t EntryRst = '{run: '0, hold: '0, period: InitDebounceRst};

endpackage

// File: hdl/bdar_update.sv
// bdar_update: next state of one button entry for one tick, and whether its flag fires
// depends on bdar_pkg
module bdar_update import bdar_pkg::*; (
  input  entry_t cur_i,
  input  logic   down_i,
  input  cfg_t   cfg_i,
  output entry_t nxt_o,
  output logic   fire_o
);

  entry_t upd;
  logic   fire;

  always_comb begin
    upd = cur_i;
    if (down_i) begin
      if (upd.run != RunMax) begin
        upd.run = upd.run + 1'b1;
      end
      if (upd.hold != HoldMax) begin
        upd.hold = upd.hold + 1'b1;
      end
      if (upd.hold > cfg_i.slow_start && upd.hold <= cfg_i.fast_start) begin
        upd.period = cfg_i.slow_period;
      end else if (upd.hold > cfg_i.fast_start && upd.hold <= cfg_i.hold_limit) begin
        upd.period = cfg_i.fast_period;
      end else if (upd.hold > cfg_i.hold_limit) begin
        // clamp just above the limit
        upd.hold = (cfg_i.hold_limit != HoldMax) ? cfg_i.hold_limit + 1'b1 : HoldMax;
      end
    end else begin
      upd.run    = '0;
      upd.hold   = '0;
      upd.period = cfg_i.init_debounce;
    end
    fire = (upd.run >= upd.period);
    if (fire) begin
      upd.run = '0;
    end
  end

  assign nxt_o  = upd;
  assign fire_o = fire;

endmodule

// File: hdl/button_debounce_auto_repeat.sv
// button_debounce_auto_repeat: tick items walk the buttons one per cycle through a state memory
// (read, update, write back); read items return and clear the sticky flags.
// a tick item holds off further items until the sequencer has issued its last button;
// a read item waits while another read is in the update stage or the output register is held,
// and its result is registered through the update stage and then the output register.
// reset: registers take their defaults and entry valid bits clear, so every button starts
// released with the initial debounce period; there is no clearing pass. depends on bdar_pkg
module button_debounce_auto_repeat import bdar_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = NumButtonsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [LevelW-1:0]   pressed_levels_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   button_flags_o
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IdxW-1:0] LastBtn = IdxW'(NUM_BUTTONS - 1);

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{init_debounce: InitDebounceRst, slow_period: SlowPeriodRst,
                 fast_period: FastPeriodRst, slow_start: SlowStartRst,
                 fast_start: FastStartRst, hold_limit: HoldLimitRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInitDebounce: cfg_q.init_debounce <= cfg_wdata_i[PerW-1:0];
        RegSlowPeriod:   cfg_q.slow_period   <= cfg_wdata_i[PerW-1:0];
        RegFastPeriod:   cfg_q.fast_period   <= cfg_wdata_i[PerW-1:0];
        RegSlowStart:    cfg_q.slow_start    <= cfg_wdata_i[HoldW-1:0];
        RegFastStart:    cfg_q.fast_start    <= cfg_wdata_i[HoldW-1:0];
        RegHoldLimit:    cfg_q.hold_limit    <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // issue stage: sequencer over the buttons
  logic                busy_q, busy_d;
  logic [IdxW-1:0]     btn_q, btn_d;
  logic [LevelW-1:0]   lev_q;
  logic                in_acc, read_ok;
  logic                iss_valid, iss_read, iss_down;
  logic [IdxW-1:0]     iss_addr;
  logic [LevelW-1:0]   lev_src;
  logic [NUM_BUTTONS-1:0] lvl_ext;

  // update stage
  logic                s1_valid_q, s1_read_q, s1_down_q;
  logic [IdxW-1:0]     s1_addr_q;
  entry_t              rdata_q;
  logic                rvld_q;
  logic                fwd_valid_q;
  logic [IdxW-1:0]     fwd_addr_q;
  entry_t              fwd_data_q;
  logic                fwd_hit;
  entry_t              s1_cur, s1_nxt;
  logic                s1_fire, s1_tick;
  logic [LevelW-1:0]   fire_mask;

  logic [NUM_BUTTONS-1:0] vld_q;
  entry_t              state_mem [NUM_BUTTONS];

  logic [LevelW-1:0]   flags_q, flags_d;
  logic                out_valid_q, out_valid_d;
  logic [LevelW-1:0]   out_flags_q;

  assign read_ok    = (!out_valid_q || out_ready_i) && !(s1_valid_q && s1_read_q);
  assign in_ready_o = !busy_q && (!action_i || read_ok);
  assign in_acc     = in_valid_i && in_ready_o;

  assign iss_valid = busy_q || in_acc;
  assign iss_read  = !busy_q && action_i;
  assign iss_addr  = busy_q ? btn_q : '0;
  assign lev_src   = busy_q ? lev_q : pressed_levels_i;

  // buttons without a level bit count as released
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lvl
    if (g < LevelW) begin : g_has
      assign lvl_ext[g] = lev_src[g];
    end else begin : g_none
      assign lvl_ext[g] = 1'b0;
    end
  end

  assign iss_down = lvl_ext[iss_addr];

  always_comb begin
    busy_d = busy_q;
    btn_d  = btn_q;
    if (busy_q) begin
      if (btn_q == LastBtn) begin
        busy_d = 1'b0;
      end else begin
        btn_d = btn_q + 1'b1;
      end
    end else if (in_acc && !action_i) begin
      busy_d = (NUM_BUTTONS > 1);
      btn_d  = IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      btn_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      rvld_q     <= 1'b0;
      vld_q      <= '0;
      flags_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      btn_q       <= btn_d;
      s1_valid_q  <= iss_valid;
      s1_read_q   <= iss_read;
      fwd_valid_q <= s1_tick;
      if (iss_valid) begin
        rvld_q <= vld_q[iss_addr];
      end
      if (s1_tick) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lev_q <= pressed_levels_i;
    end
    if (iss_valid) begin
      s1_addr_q <= iss_addr;
      s1_down_q <= iss_down;
      rdata_q   <= state_mem[iss_addr];
    end
    if (s1_tick) begin
      state_mem[s1_addr_q] <= s1_nxt;
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= s1_nxt;
    end
    if (s1_valid_q && s1_read_q) begin
      out_flags_q <= flags_q;
    end
  end

  // a write from the previous cycle is not yet seen by a read of the same entry
  assign s1_tick = s1_valid_q && !s1_read_q;
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == s1_addr_q);
  assign s1_cur  = fwd_hit ? fwd_data_q : (rvld_q ? rdata_q : EntryRst);

  bdar_update u_update (
    .cur_i  (s1_cur),
    .down_i (s1_down_q),
    .cfg_i  (cfg_q),
    .nxt_o  (s1_nxt),
    .fire_o (s1_fire)
  );

  for (genvar j = 0; j < LevelW; j++) begin : g_fire
    assign fire_mask[j] = s1_tick && s1_fire && (32'(s1_addr_q) == j);
  end

  always_comb begin
    flags_d     = flags_q | fire_mask;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (s1_valid_q && s1_read_q) begin
      flags_d     = '0;
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_flags_o = out_flags_q;

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !in_ready_o)
    else $error("item accepted while buttons still being served");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_read_q) |-> (!out_valid_q || out_ready_i))
    else $error("read item reached update stage with output register occupied");

  a_flags_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_read_q) |=> (flags_q == '0))
    else $error("flags not cleared after read item");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_read_q))
    else $error("result shown without a read item");

  a_fwd_only_ticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> $past(s1_valid_q && !s1_read_q))
    else $error("forwarding entry not from a tick update");

endmodule

// File: tb/button_debounce_auto_repeat_tb.sv
// button_debounce_auto_repeat_tb: self-checking bench for the debounce and auto-repeat block
// holds a flag scoreboard with its own per-button state; drives items, register writes, stalls
// depends on bdar_pkg and button_debounce_auto_repeat
module button_debounce_auto_repeat_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdar_pkg::*;

  localparam logic        ActTick      = 1'b0;
  localparam logic        ActRead      = 1'b1;
  localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;
  localparam int          SettleCycles = 16;
  localparam int          StallLimit   = 2000;
  localparam int          HoldOffLen   = 400;
  localparam int          NumPhases    = 14;

  class flag_scoreboard;
    cfg_t              cfg;
    entry_t            btn [NumButtonsDef];
    logic [LevelW-1:0] sticky;
    logic [LevelW-1:0] flags_due [$];
    int                errors;

    function new();
      int i;
      cfg = '{init_debounce: InitDebounceRst, slow_period: SlowPeriodRst,
              fast_period: FastPeriodRst, slow_start: SlowStartRst,
              fast_start: FastStartRst, hold_limit: HoldLimitRst};
      for (i = 0; i < NumButtonsDef; i++) btn[i] = EntryRst;
      sticky = '0;
      errors = 0;
    endfunction

    function void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegInitDebounce: cfg.init_debounce = data[PerW-1:0];
        RegSlowPeriod:   cfg.slow_period   = data[PerW-1:0];
        RegFastPeriod:   cfg.fast_period   = data[PerW-1:0];
        RegSlowStart:    cfg.slow_start    = data;
        RegFastStart:    cfg.fast_start    = data;
        RegHoldLimit:    cfg.hold_limit    = data;
        default: ;
      endcase
    endfunction

    function void note_item(logic act, logic [LevelW-1:0] levels);
      entry_t e;
      int     i;
      if (act == ActRead) begin
        flags_due.push_back(sticky);
        sticky = '0;
      end else begin
        for (i = 0; i < NumButtonsDef; i++) begin
          e = btn[i];
          if (levels[i]) begin
            if (e.run != RunMax) e.run = e.run + 1'b1;
            if (e.hold != HoldMax) e.hold = e.hold + 1'b1;
            // first matching window wins; past the limit the timer is pinned
            if (e.hold > cfg.slow_start && e.hold <= cfg.fast_start) begin
              e.period = cfg.slow_period;
            end else if (e.hold > cfg.fast_start && e.hold <= cfg.hold_limit) begin
              e.period = cfg.fast_period;
            end else if (e.hold > cfg.hold_limit) begin
              e.hold = (cfg.hold_limit != HoldMax) ? cfg.hold_limit + 16'd1 : HoldMax;
            end
          end else begin
            e = '{run: '0, hold: '0, period: cfg.init_debounce};
          end
          // a zero period fires on every tick, released or not
          if (e.run >= e.period) begin
            sticky[i] = 1'b1;
            e.run = '0;
          end
          btn[i] = e;
        end
      end
    endfunction

    function void check_flags(logic [LevelW-1:0] got);
      logic [LevelW-1:0] want;
      if (flags_due.size() == 0) begin
        $display("%0t: button_flags expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = flags_due.pop_front();
        if (got !== want) begin
          $display("%0t: button_flags expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i        = '0;
  logic [CfgDataW-1:0] cfg_wdata_i      = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_ready_o;
  logic                action_i         = 1'b0;
  logic [LevelW-1:0]   pressed_levels_i = '0;
  logic                out_valid_o;
  logic                out_ready_i      = 1'b0;
  logic [LevelW-1:0]   button_flags_o;

  flag_scoreboard sb;
  bit             calm        = 1'b0;
  int             squeeze_req = 0;
  int             quiet_cycles = 0;

  button_debounce_auto_repeat DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .pressed_levels_i (pressed_levels_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .button_flags_o   (button_flags_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results are checked before the item of the same edge is noted
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (out_valid_o && out_ready_i) sb.check_flags(button_flags_o);
      if (in_valid_i && in_ready_o) sb.note_item(action_i, pressed_levels_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("button_debounce_auto_repeat: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int seen;
    int hold_off;
    seen = 0;
    hold_off = 0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req != seen) begin
        seen = squeeze_req;
        hold_off = HoldOffLen;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 6);
      end
    end
  end

  task automatic send_item(input logic act, input logic [LevelW-1:0] levels);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    pressed_levels_i <= levels;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.apply_reg(idx, data);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(RegInitDebounce, CfgDataW'(c.init_debounce));
    write_reg(RegSlowPeriod,   CfgDataW'(c.slow_period));
    write_reg(RegFastPeriod,   CfgDataW'(c.fast_period));
    write_reg(RegSlowStart,    c.slow_start);
    write_reg(RegFastStart,    c.fast_start);
    write_reg(RegHoldLimit,    c.hold_limit);
  endtask

  // stop offering, wait for every read to be answered, then let a tick finish
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.flags_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic cfg_t small_cfg();
    cfg_t c;
    c.init_debounce = PerW'($urandom_range(1, 8));
    c.slow_period   = PerW'($urandom_range(1, 12));
    c.fast_period   = PerW'($urandom_range(1, 6));
    c.slow_start    = HoldW'($urandom_range(0, 20));
    if ($urandom_range(0, 3) == 0) begin
      c.fast_start = HoldW'($urandom_range(0, 20));
    end else begin
      c.fast_start = c.slow_start + HoldW'($urandom_range(0, 25));
    end
    if ($urandom_range(0, 3) == 0) begin
      c.hold_limit = HoldW'($urandom_range(0, 60));
    end else begin
      c.hold_limit = c.fast_start + HoldW'($urandom_range(0, 30));
    end
    return c;
  endfunction

  // buttons follow press and release runs; some ticks carry contact bounce instead
  task automatic run_phase(input int n_items, input int read_pct, input int bounce_pct,
                           input int max_press);
    logic [LevelW-1:0] held;
    logic [LevelW-1:0] levels;
    int                run_left [LevelW];
    int                k;
    int                b;
    held = '0;
    for (b = 0; b < LevelW; b++) run_left[b] = $urandom_range(1, 4);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < read_pct) begin
        send_item(ActRead, LevelW'($urandom_range(0, 15)));
      end else begin
        levels = held;
        if ($urandom_range(0, 99) < bounce_pct) levels = LevelW'($urandom_range(0, 15));
        send_item(ActTick, levels);
        for (b = 0; b < LevelW; b++) begin
          run_left[b] = run_left[b] - 1;
          if (run_left[b] == 0) begin
            held[b] = ~held[b];
            run_left[b] = held[b] ? $urandom_range(1, max_press) : $urandom_range(1, 6);
          end
        end
      end
    end
    send_item(ActRead, LevelW'($urandom_range(0, 15)));
    drain();
  endtask

  initial begin
    cfg_t c;
    int   p;
    int   press_cap;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // state straight after reset, default registers
    send_item(ActRead, 4'hF);
    send_item(ActTick, 4'hF);
    send_item(ActTick, 4'h0);
    send_item(ActRead, 4'h0);
    drain();

    // short windows so one press walks debounce, slow, fast and the clamp
    c = '{init_debounce: 10'd2, slow_period: 10'd3, fast_period: 10'd1,
          slow_start: 16'd3, fast_start: 16'd6, hold_limit: 16'd8};
    load_config(c);
    write_reg(RegSpareLow, 16'hFFFF);
    write_reg(RegSpareHigh, 16'hFFFF);
    cfg_we_i <= 1'b0;
    repeat (10) send_item(ActTick, 4'hF);
    send_item(ActRead, 4'h0);
    send_item(ActTick, 4'h5);
    send_item(ActTick, 4'hA);
    send_item(ActTick, 4'h0);
    send_item(ActRead, 4'hF);
    send_item(ActRead, 4'h0);
    send_item(ActTick, 4'h3);
    send_item(ActTick, 4'h3);
    send_item(ActRead, 4'h5);
    drain();

    for (p = 0; p < NumPhases; p++) begin
      calm = (p == 5 || p == 9);
      case (p)
        0: c = '{init_debounce: 10'd1, slow_period: 10'd1, fast_period: 10'd1,
                 slow_start: 16'd0, fast_start: 16'd0, hold_limit: 16'd0};
        1: c = '{init_debounce: 10'd1023, slow_period: 10'd1023, fast_period: 10'd1023,
                 slow_start: 16'd65534, fast_start: 16'd65534, hold_limit: 16'd65534};
        2: begin
          c = small_cfg();
          c.init_debounce = '0;
        end
        4: c = '{init_debounce: 10'd10, slow_period: 10'd20, fast_period: 10'd5,
                 slow_start: 16'd30, fast_start: 16'd100, hold_limit: 16'd150};
        default: c = small_cfg();
      endcase
      load_config(c);
      // bits above the 10-bit period field must be dropped
      if (p == 2) write_reg(RegSlowPeriod, 16'hFC03);
      cfg_we_i <= 1'b0;
      press_cap = int'(c.hold_limit) + 20;
      if (press_cap > 220) press_cap = 220;
      case (p)
        1: run_phase(60, 12, 8, press_cap);
        3: begin
          squeeze_req++;
          run_phase(100, 45, 8, press_cap);
        end
        4: run_phase(300, 5, 4, 200);
        default: run_phase(120, 12, 10, press_cap);
      endcase
    end

    if (sb.flags_due.size() != 0) begin
      $display("%0t: %0d button_flags results never arrived", $time, sb.flags_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("button_debounce_auto_repeat: match");
    end else begin
      $display("button_debounce_auto_repeat: mismatch");
    end
    $finish;
  end

endmodule
